// ----- sv/pvmpg_pkg.sv -----
// shared constants, codes and palette helpers for the two-plane pixel generator
package pvmpg_pkg;

  localparam int unsigned MemoryBytes = 32768;
  localparam int unsigned PlaneBytes  = MemoryBytes / 2;
  localparam int unsigned PlaneAw     = $clog2(PlaneBytes);
  localparam int unsigned CpuAw       = $clog2(MemoryBytes);

  localparam int unsigned KindW  = 2;
  localparam int unsigned CellW  = 14;
  localparam int unsigned DataW  = 8;
  localparam int unsigned PixW   = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 6;

  localparam logic [KindW-1:0] KIND_WRITE = 2'd0;
  localparam logic [KindW-1:0] KIND_READ  = 2'd1;
  localparam logic [KindW-1:0] KIND_FETCH = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_EXT_CONTROL = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GRAPHICS_ON = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ALT_PALETTE = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_COLOR_SEL   = 2'd3;

  // 16-colour table: 0x10 | idx[2:0] << 1 | idx[3]
  function automatic logic [PixW-1:0] pal16(input logic [3:0] idx);
    return {1'b1, idx[2:0], idx[3]};
  endfunction

  // 4-colour palette of the 640-wide mode
  function automatic logic [PixW-1:0] pal4(input logic [1:0] idx,
                                           input logic [5:0] color_sel,
                                           input logic alt_pal);
    logic [2:0] lo;
    lo = 3'd0;
    case (idx)
      2'd1: lo = (alt_pal || color_sel[5]) ? 3'd3 : 3'd2;
      2'd2: lo = alt_pal ? 3'd4 : (color_sel[5] ? 3'd5 : 3'd4);
      2'd3: lo = (alt_pal || color_sel[5]) ? 3'd7 : 3'd6;
      default: lo = 3'd0;
    endcase
    if (idx == 2'd0) begin
      return {1'b1, color_sel[3:0]};
    end
    return {1'b1, color_sel[4], lo};
  endfunction

endpackage

// ----- sv/pvmpg_req_if.sv -----
// request channel: cpu accesses and cell fetches
interface pvmpg_req_if
  import pvmpg_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [CpuAw-1:0] address;
  logic [DataW-1:0] write_data;
  logic [CellW-1:0] cell_address;
  logic             row_odd;

  modport source (output valid, kind, address, write_data, cell_address, row_odd,
                  input ready);
  modport sink   (input valid, kind, address, write_data, cell_address, row_odd,
                  output ready);
endinterface

// ----- sv/pvmpg_rsp_if.sv -----
// result channel: pixel indices and cpu read data
interface pvmpg_rsp_if
  import pvmpg_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0]  pixel_index;
  logic [DataW-1:0] read_data;
  logic             last;

  modport source (output valid, pixel_index, read_data, last, input ready);
  modport sink   (input valid, pixel_index, read_data, last, output ready);
endinterface

// ----- sv/pvmpg_ram.sv -----
// single-port synchronous ram, registered read data held between reads
module pvmpg_ram #(
  parameter int unsigned Depth = 16384,
  parameter int unsigned Width = 8,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/planar_video_memory_pixel_generator_top.sv -----
// top level: two-plane video memory, cpu port remap and cell fetch pixel sequencer
//
// Video memory is two 16 KiB single-port planes, one read or write per plane per
// cycle, not cleared by reset. A cpu write goes to its plane as it is accepted. A
// cpu read passes its result through the plane read register and then the output
// register, and the next request is taken once that result sits in the output
// register. A cell fetch in an extended graphics mode reads two bytes per plane,
// high byte first, then sends sixteen pixel indices at one per cycle while the
// result channel is ready; no new request is taken until the last index sits in
// the output register. A fetch outside the extended modes is accepted and gives nothing.
module planar_video_memory_pixel_generator_top
  import pvmpg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  pvmpg_req_if.sink          req_i,
  pvmpg_rsp_if.source        rsp_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_LOW   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [2:0] ext_q;
  logic       gfx_q;
  logic       alt_q;
  logic [5:0] csel_q;

  logic             out_valid_q, out_valid_d;
  logic [PixW-1:0]  out_pix_q, out_pix_d;
  logic [DataW-1:0] out_data_q, out_data_d;
  logic             out_last_q, out_last_d;

  logic [15:0] d0_q, d0_d, d1_q, d1_d;
  logic [11:0] cell_q, cell_d;
  logic        odd_q, odd_d;
  logic        plane_q, plane_d;

  logic              accept, out_free, mode_any, ext_gfx;
  logic [CpuAw-1:0]  cpu_addr;
  logic              ram_en, ram_we0, ram_we1;
  logic [PlaneAw-1:0] ram_addr;
  logic [DataW-1:0]  rdata0, rdata1;

  assign mode_any = |ext_q[1:0];
  assign ext_gfx  = mode_any && gfx_q;
  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  always_comb begin
    cpu_addr = req_i.address;
    if (ext_q[2] && ext_gfx) begin
      cpu_addr[CpuAw-1] = ~req_i.address[CpuAw-1];
    end else if (!mode_any) begin
      cpu_addr[CpuAw-1] = 1'b0;
    end
  end

  pvmpg_ram #(.Depth(PlaneBytes), .Width(DataW)) u_plane0 (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we0),
    .addr_i  (ram_addr),
    .wdata_i (req_i.write_data),
    .rdata_o (rdata0)
  );

  pvmpg_ram #(.Depth(PlaneBytes), .Width(DataW)) u_plane1 (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we1),
    .addr_i  (ram_addr),
    .wdata_i (req_i.write_data),
    .rdata_o (rdata1)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_pix_d  = out_pix_q;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    d0_d       = d0_q;
    d1_d       = d1_q;
    cell_d     = cell_q;
    odd_d      = odd_q;
    plane_d    = plane_q;
    ram_en     = 1'b0;
    ram_we0    = 1'b0;
    ram_we1    = 1'b0;
    ram_addr   = cpu_addr[PlaneAw-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.kind)
            KIND_WRITE: begin
              ram_en  = 1'b1;
              ram_we0 = !cpu_addr[CpuAw-1];
              ram_we1 = cpu_addr[CpuAw-1];
            end
            KIND_READ: begin
              ram_en  = 1'b1;
              plane_d = cpu_addr[CpuAw-1];
              state_d = ST_READ;
            end
            KIND_FETCH: begin
              if (ext_gfx) begin
                ram_en   = 1'b1;
                ram_addr = {req_i.row_odd, req_i.cell_address[11:0], 1'b0};
                cell_d   = req_i.cell_address[11:0];
                odd_d    = req_i.row_odd;
                state_d  = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pix_d   = '0;
          out_data_d  = plane_q ? rdata1 : rdata0;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_FETCH: begin
        ram_en         = 1'b1;
        ram_addr       = {odd_q, cell_q, 1'b1};
        d0_d[15:8]     = rdata0;
        d1_d[15:8]     = rdata1;
        state_d        = ST_LOW;
      end
      ST_LOW: begin
        d0_d[7:0] = rdata0;
        d1_d[7:0] = rdata1;
        cnt_d     = '0;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_last_d  = (cnt_q == 4'd15);
          if (ext_q[0]) begin
            out_pix_d = pal16({d1_q[15:14], d0_q[15:14]});
            if (cnt_q[0]) begin
              d0_d = {d0_q[13:0], 2'b00};
              d1_d = {d1_q[13:0], 2'b00};
            end
          end else begin
            out_pix_d = pal4({d1_q[15], d0_q[15]}, csel_q, alt_q);
            d0_d      = {d0_q[14:0], 1'b0};
            d1_d      = {d1_q[14:0], 1'b0};
          end
          cnt_d = cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      ext_q       <= '0;
      gfx_q       <= 1'b0;
      alt_q       <= 1'b0;
      csel_q      <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_EXT_CONTROL: ext_q  <= cfg_wdata_i[2:0];
          REG_GRAPHICS_ON: gfx_q  <= cfg_wdata_i[0];
          REG_ALT_PALETTE: alt_q  <= cfg_wdata_i[0];
          REG_COLOR_SEL:   csel_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_pix_q  <= out_pix_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    d0_q       <= d0_d;
    d1_q       <= d1_d;
    cell_q     <= cell_d;
    odd_q      <= odd_d;
    plane_q    <= plane_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.pixel_index = out_pix_q;
  assign rsp_o.read_data   = out_data_q;
  assign rsp_o.last        = out_last_q;

endmodule
